// File: hw/rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue with search.
// Used by spq_store, spq_cmp and the top level; depends on nothing.
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OCC_W     = 5;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_HIT      = 3'd3;
	localparam logic [2:0] ST_MISS     = 3'd4;

	typedef struct packed {
		logic [63:0] id;
		logic [15:0] fuel;
		logic [63:0] dest;
	} entry_t;

	typedef struct packed {
		logic le;     // stored key <= request key
		logic id_eq;  // stored id == request id
	} cmp_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_store.sv
// Entry memory: one write port, one read port with registered read data.
// Depends on spq_pkg for entry_t.
`default_nettype none

module spq_store import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/spq_cmp.sv
// Shared comparator: key order (fuel, then destination) and id match.
// Depends on spq_pkg for entry_t and cmp_t.
`default_nettype none

module spq_cmp import spq_pkg::*; (
	input  wire entry_t stored,
	input  wire entry_t req,
	output cmp_t        res
);

	always_comb begin
		if (stored.fuel != req.fuel) begin
			res.le = stored.fuel < req.fuel;
		end else begin
			res.le = stored.dest <= req.dest;
		end
		res.id_eq = stored.id == req.id;
	end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_priority_queue_with_search_unit.sv
// Top level of the sorted priority queue with search: sequencer, output register.
// Depends on spq_pkg, spq_store (entry memory) and spq_cmp (shared comparator).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in      | to block  | in_valid/in_stall  | operation, flight_id, fuel, destination
//   out     | from block| out_valid/out_stall| status, found_id, found_fuel,
//           |           |                    | found_destination, occupancy
//
// Requests: one at a time, paced by the one read port and comparator; a full or
// empty-store insert, an empty pop or search, and code three finish without a walk.
// Reset: arst_n clears sequencer, count and output valid; memory is not cleared.
// Stalls: in_stall is high while a request is in work; a result waits in the output
// register under out_stall and the next request is still taken.
`default_nettype none

module sorted_priority_queue_with_search_unit import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [63:0] flight_id,
	input  wire logic [15:0] fuel,
	input  wire logic [63:0] destination,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [63:0]      found_id,
	output logic [15:0]      found_fuel,
	output logic [63:0]      found_destination,
	output logic [OCC_W-1:0] occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1; // walk back from tail, shifting larger keys up
	localparam logic [2:0] S_INSH = 3'd2; // new entry goes to the head slot
	localparam logic [2:0] S_POP  = 3'd3; // take slot 0, shift the rest down
	localparam logic [2:0] S_SRCH = 3'd4; // walk forward looking for the id
	localparam logic [2:0] S_DONE = 3'd5; // hand the result to the output register

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] ptr_q, ptr_d;   // slot whose data the memory returns this cycle

	entry_t        req_q;          // request held for the walk
	entry_t        res_q;          // payload of the result being built
	logic [2:0]    res_status_q;

	logic          out_valid_q;
	logic [2:0]    status_q;
	entry_t        out_q;
	logic [OCC_W-1:0] occ_q;

	entry_t        in_entry;
	entry_t        rdata;
	entry_t        wdata;
	cmp_t          cmp;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic          accept, cap, stat_ld, load_out, last;
	logic [2:0]    stat_d;

	assign in_entry = '{id: flight_id, fuel: fuel, dest: destination};
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = state_q != S_IDLE;

	// current slot is the last stored one
	assign last = (CW'(ptr_q) + CW'(1)) == cnt_q;

	spq_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	spq_cmp u_cmp (
		.stored (rdata),
		.req    (req_q),
		.res    (cmp)
	);

	// Sequencer. Each read is issued in the cycle before its data is used, so the
	// walk covers one slot per cycle; writes land on a read slot or the one past the tail.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		we       = 1'b0;
		waddr    = '0;
		wdata    = rdata;
		re       = 1'b0;
		raddr    = '0;
		cap      = 1'b0;
		stat_ld  = 1'b0;
		stat_d   = ST_MISS;
		load_out = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					stat_ld = 1'b1;
					state_d = S_DONE;
					unique case (operation)
						OP_INSERT: begin
							if (cnt_q == CW'(DEPTH)) begin
								stat_d = ST_FULL;
							end else if (cnt_q == '0) begin
								we     = 1'b1;
								wdata  = in_entry;
								cnt_d  = cnt_q + CW'(1);
								stat_d = ST_INSERTED;
							end else begin
								stat_ld = 1'b0;
								re      = 1'b1;
								raddr   = AW'(cnt_q - CW'(1));
								ptr_d   = AW'(cnt_q - CW'(1));
								state_d = S_INS;
							end
						end
						OP_POP: begin
							if (cnt_q == '0) begin
								stat_d = ST_EMPTY;
							end else begin
								stat_ld = 1'b0;
								re      = 1'b1;
								ptr_d   = '0;
								state_d = S_POP;
							end
						end
						OP_SEARCH: begin
							if (cnt_q != '0) begin
								stat_ld = 1'b0;
								re      = 1'b1;
								ptr_d   = '0;
								state_d = S_SRCH;
							end
						end
						default: begin
							stat_d = ST_MISS;
						end
					endcase
				end
			end
			S_INS: begin
				we    = 1'b1;
				waddr = ptr_q + AW'(1);
				if (cmp.le) begin
					// stored key <= new key: new entry sits right behind it
					wdata   = req_q;
					cnt_d   = cnt_q + CW'(1);
					stat_ld = 1'b1;
					stat_d  = ST_INSERTED;
					state_d = S_DONE;
				end else if (ptr_q == '0) begin
					state_d = S_INSH;
				end else begin
					re    = 1'b1;
					raddr = ptr_q - AW'(1);
					ptr_d = ptr_q - AW'(1);
				end
			end
			S_INSH: begin
				we      = 1'b1;
				wdata   = req_q;
				cnt_d   = cnt_q + CW'(1);
				stat_ld = 1'b1;
				stat_d  = ST_INSERTED;
				state_d = S_DONE;
			end
			S_POP: begin
				if (ptr_q == '0) begin
					cap = 1'b1;
				end else begin
					we    = 1'b1;
					waddr = ptr_q - AW'(1);
				end
				if (last) begin
					cnt_d   = cnt_q - CW'(1);
					stat_ld = 1'b1;
					stat_d  = ST_HIT;
					state_d = S_DONE;
				end else begin
					re    = 1'b1;
					raddr = ptr_q + AW'(1);
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_SRCH: begin
				if (cmp.id_eq) begin
					cap     = 1'b1;
					stat_ld = 1'b1;
					stat_d  = ST_HIT;
					state_d = S_DONE;
				end else if (last) begin
					stat_ld = 1'b1;
					stat_d  = ST_MISS;
					state_d = S_DONE;
				end else begin
					re    = 1'b1;
					raddr = ptr_q + AW'(1);
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ptr_q   <= ptr_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload; result fields default to zero unless an entry is captured
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_entry;
			res_q <= '0;
		end
		if (cap) begin
			res_q <= rdata;
		end
		if (stat_ld) begin
			res_status_q <= stat_d;
		end
		if (load_out) begin
			status_q <= res_status_q;
			out_q    <= res_q;
			occ_q    <= OCC_W'(cnt_q);
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign found_id          = out_q.id;
	assign found_fuel        = out_q.fuel;
	assign found_destination = out_q.dest;
	assign occupancy         = occ_q;

endmodule

`default_nettype wire
